// ----- hw/rtl/disc_elastic_collision_unit_defines.svh -----
// ----------------------------------------------------------------------------
// disc_elastic_collision_unit_defines.svh
// assertion macros used by the collision unit checker
// ----------------------------------------------------------------------------
`ifndef DISC_ELASTIC_COLLISION_UNIT_DEFINES_SVH
`define DISC_ELASTIC_COLLISION_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DEC_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication after a fixed number of cycles, disabled during reset
`define DEC_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/dec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dec_pkg
// types, constants and helper functions of the disc collision unit
// ----------------------------------------------------------------------------
package dec_pkg;

    localparam int COORD_WIDTH_DEF   = 32;
    localparam int ROTATOR_STEPS_DEF = 16;
    localparam int RADIUS_W          = 30;
    localparam int W                 = 64;
    localparam int PW                = 2 * W;
    localparam int HW                = W / 2;
    localparam int NORM_TOP          = 60;
    localparam int FRAC_SH           = 30;
    localparam int GAIN_SH           = 61;
    localparam int QW                = RADIUS_W + 2;
    localparam int MW                = RADIUS_W + 1;
    localparam int DIV_BITS          = 4;
    localparam int DIV_STAGES        = QW / DIV_BITS;

    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
    } t_xy;

    typedef struct packed {
        t_xy a;
        t_xy b;
    } t_quad;

    // one micro-rotation, cw turns toward the x axis for positive y
    function automatic t_xy turn(input t_xy v, input int unsigned sh, input logic cw);
        t_xy r;
        if (cw) begin
            r.x = v.x + (v.y >>> sh);
            r.y = v.y - (v.x >>> sh);
        end else begin
            r.x = v.x - (v.y >>> sh);
            r.y = v.y + (v.x >>> sh);
        end
        return r;
    endfunction

    // inverse squared rotator gain in q61, long division done bit by bit
    function automatic logic [W-1:0] gain_q61(input int steps);
        logic [W-1:0] g;
        logic [W-1:0] d;
        logic [W-1:0] q;
        logic [W:0]   rem;
        g = W'(1) << GAIN_SH;
        for (int i = 0; i < steps; i++) begin
            d   = (W'(1) << (2 * i)) + W'(1);
            rem = '0;
            q   = '0;
            for (int b = W - 1; b >= 0; b--) begin
                rem = {rem[W-1:0], g[b]};
                if (rem >= {1'b0, d}) begin
                    rem  = rem - {1'b0, d};
                    q[b] = 1'b1;
                end
            end
            g = g - q;
        end
        return g;
    endfunction

endpackage

// ----- hw/rtl/dec_wmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dec_wmul
// signed 64x64 multiplier, three register stages, 32x32 partial products
// ----------------------------------------------------------------------------
module dec_wmul (
    input  logic                              i_clk,
    input  logic signed [dec_pkg::W-1:0]      i_a,
    input  logic signed [dec_pkg::W-1:0]      i_b,
    output logic signed [dec_pkg::PW-1:0]     o_p
);

    localparam int W  = dec_pkg::W;
    localparam int PW = dec_pkg::PW;
    localparam int HW = dec_pkg::HW;

    logic [W-1:0]         r_ma;
    logic [W-1:0]         r_mb;
    logic                 r_sg1;
    logic [W-1:0]         r_pp [0:3];
    logic                 r_sg2;
    logic signed [PW-1:0] r_p;
    logic [PW-1:0]        n_sum;

    always_ff @(posedge i_clk) begin
        r_ma  <= i_a[W-1] ? W'(~i_a) + W'(1) : W'(i_a);
        r_mb  <= i_b[W-1] ? W'(~i_b) + W'(1) : W'(i_b);
        r_sg1 <= i_a[W-1] ^ i_b[W-1];
    end

    always_ff @(posedge i_clk) begin
        r_pp[0] <= W'(r_ma[HW-1:0]) * W'(r_mb[HW-1:0]);
        r_pp[1] <= W'(r_ma[HW-1:0]) * W'(r_mb[W-1:HW]);
        r_pp[2] <= W'(r_ma[W-1:HW]) * W'(r_mb[HW-1:0]);
        r_pp[3] <= W'(r_ma[W-1:HW]) * W'(r_mb[W-1:HW]);
        r_sg2   <= r_sg1;
    end

    always_comb begin
        n_sum = PW'(r_pp[0]) + (PW'(r_pp[1]) << HW) + (PW'(r_pp[2]) << HW)
              + (PW'(r_pp[3]) << W);
    end

    always_ff @(posedge i_clk) begin
        r_p <= signed'(r_sg2 ? ~n_sum + PW'(1) : n_sum);
    end

    assign o_p = r_p;

endmodule

// ----- hw/rtl/disc_elastic_collision_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disc_elastic_collision_unit
// two-disc elastic collision: approach test, rotator frame, normal exchange
// ----------------------------------------------------------------------------
// channel   | handshake         | payload
// request   | i_start / o_busy  | i_pos_*, i_vel_*, i_radius_a, i_radius_b
// result    | o_done            | o_new_vel_*, o_resolved
//
// one request per cycle; o_busy is always low
// the pipeline length is set mostly by the forward and backward rotator
// chains, one micro-rotation per stage
// i_rst_n clears only the valid pipe; results cannot be held off
// ----------------------------------------------------------------------------
module disc_elastic_collision_unit #(
    parameter int COORD_WIDTH   = dec_pkg::COORD_WIDTH_DEF,
    parameter int ROTATOR_STEPS = dec_pkg::ROTATOR_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic signed [COORD_WIDTH-1:0]       i_pos_a_x,
    input  logic signed [COORD_WIDTH-1:0]       i_pos_a_y,
    input  logic signed [COORD_WIDTH-1:0]       i_vel_a_x,
    input  logic signed [COORD_WIDTH-1:0]       i_vel_a_y,
    input  logic [dec_pkg::RADIUS_W-1:0]        i_radius_a,
    input  logic signed [COORD_WIDTH-1:0]       i_pos_b_x,
    input  logic signed [COORD_WIDTH-1:0]       i_pos_b_y,
    input  logic signed [COORD_WIDTH-1:0]       i_vel_b_x,
    input  logic signed [COORD_WIDTH-1:0]       i_vel_b_y,
    input  logic [dec_pkg::RADIUS_W-1:0]        i_radius_b,
    output logic                                o_done,
    output logic signed [COORD_WIDTH-1:0]       o_new_vel_a_x,
    output logic signed [COORD_WIDTH-1:0]       o_new_vel_a_y,
    output logic signed [COORD_WIDTH-1:0]       o_new_vel_b_x,
    output logic signed [COORD_WIDTH-1:0]       o_new_vel_b_y,
    output logic                                o_resolved
);

    localparam int W        = dec_pkg::W;
    localparam int PW       = dec_pkg::PW;
    localparam int HW       = dec_pkg::HW;
    localparam int QW       = dec_pkg::QW;
    localparam int MW       = dec_pkg::MW;
    localparam int N        = ROTATOR_STEPS;
    localparam int DS       = dec_pkg::DIV_STAGES;
    localparam int DIV_LAT  = DS + 1;
    localparam int S_APF    = 6;
    localparam int S_ROT0   = 3;
    localparam int S_ROTL   = N + 2;
    localparam int S_DIFF   = N + 3;
    localparam int S_EXC    = N + 7;
    localparam int S_BKL    = 2 * N + 7;
    localparam int S_GAIN   = 2 * N + 10;
    localparam int S_OUT    = 2 * N + 11;
    localparam logic signed [W-1:0] G = signed'(dec_pkg::gain_q61(N));

    // ---------------- valid pipe ----------------
    logic [S_OUT:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[S_OUT-1:0], i_start};
        end
    end

    assign o_busy = 1'b0;
    assign o_done = r_vld[S_OUT];

    // ---------------- stage 0 ----------------
    dec_pkg::t_quad  r_wv [0:S_GAIN];
    dec_pkg::t_quad  r_ov [0:S_GAIN];
    logic            r_fr [0:S_GAIN];
    dec_pkg::t_xy    r_cv [0:S_ROTL];
    logic [N-1:0]    r_dir [S_ROT0:S_BKL];
    logic [W-1:0]    r_mag;
    logic signed [W-1:0] r_dx, r_dy, r_dvx, r_dvy;

    logic [QW:0]     r_drem [0:DS];
    logic [QW-1:0]   r_dq   [0:DS];
    logic [QW-1:0]   r_dn   [0:DS];
    logic [MW-1:0]   r_dm   [0:DS];

    dec_pkg::t_quad  n_v0;
    dec_pkg::t_xy    n_n0;
    logic signed [W-1:0] n_pax, n_pay, n_pbx, n_pby;

    always_comb begin
        n_v0.a.x = W'(i_vel_a_x);
        n_v0.a.y = W'(i_vel_a_y);
        n_v0.b.x = W'(i_vel_b_x);
        n_v0.b.y = W'(i_vel_b_y);
        n_pax    = W'(i_pos_a_x);
        n_pay    = W'(i_pos_a_y);
        n_pbx    = W'(i_pos_b_x);
        n_pby    = W'(i_pos_b_y);
        n_n0.x   = n_pbx - n_pax;
        n_n0.y   = n_pby - n_pay;
        // centre line kept in the right half plane
        if (n_n0.x[W-1]) begin
            n_n0.x = -n_n0.x;
            n_n0.y = -n_n0.y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wv[0]   <= n_v0;
        r_ov[0]   <= n_v0;
        r_cv[0]   <= n_n0;
        r_fr[0]   <= (n_n0.x != '0) || (n_n0.y != '0);
        r_dx      <= n_pax - n_pbx;
        r_dy      <= n_pay - n_pby;
        r_dvx     <= n_v0.a.x - n_v0.b.x;
        r_dvy     <= n_v0.a.y - n_v0.b.y;
        r_drem[0] <= (QW+1)'(i_radius_b >> 1);
        r_dq[0]   <= '0;
        r_dn[0]   <= {i_radius_b[0], (QW-1)'(0)};
        r_dm[0]   <= MW'(i_radius_a) + MW'(i_radius_b);
    end

    // ---------------- side pipes ----------------
    genvar s;
    generate
        for (s = 1; s <= S_GAIN; s++) begin : g_side
            always_ff @(posedge i_clk) begin
                r_ov[s] <= r_ov[s-1];
                r_fr[s] <= r_fr[s-1];
            end
        end
    endgenerate

    // ---------------- approach test ----------------
    logic signed [PW-1:0] w_px, w_py, w_qx, w_qy;
    logic signed [PW-1:0] r_ps, r_pq, r_pt;
    logic                 r_ap [S_APF:S_GAIN];

    dec_wmul u_mul_px (.i_clk(i_clk), .i_a(r_dx),  .i_b(r_dvx), .o_p(w_px));
    dec_wmul u_mul_py (.i_clk(i_clk), .i_a(r_dy),  .i_b(r_dvy), .o_p(w_py));
    dec_wmul u_mul_qx (.i_clk(i_clk), .i_a(r_dvx), .i_b(r_dvx), .o_p(w_qx));
    dec_wmul u_mul_qy (.i_clk(i_clk), .i_a(r_dvy), .i_b(r_dvy), .o_p(w_qy));

    always_ff @(posedge i_clk) begin
        r_ps        <= w_px + w_py;
        r_pq        <= w_qx + w_qy;
        // 200 = 128 + 64 + 8
        r_pt        <= (r_ps <<< 7) + (r_ps <<< 6) + (r_ps <<< 3) + r_pq;
        r_ap[S_APF] <= r_pt[PW-1] || (r_pt == '0);
    end

    generate
        for (s = S_APF + 1; s <= S_GAIN; s++) begin : g_ap
            always_ff @(posedge i_clk) begin
                r_ap[s] <= r_ap[s-1];
            end
        end
    endgenerate

    // ---------------- mass fraction divider ----------------
    logic [QW-1:0] r_fa [DIV_LAT:S_DIFF];
    logic [QW-1:0] r_fb [DIV_LAT:S_DIFF];

    genvar k;
    generate
        for (k = 1; k <= DS; k++) begin : g_div
            logic [QW:0]   n_rem;
            logic [QW:0]   n_t;
            logic [QW-1:0] n_q;
            logic [QW-1:0] n_n;

            always_comb begin
                n_rem = r_drem[k-1];
                n_q   = r_dq[k-1];
                n_n   = r_dn[k-1];
                n_t   = '0;
                for (int j = 0; j < dec_pkg::DIV_BITS; j++) begin
                    n_t = {n_rem[QW-1:0], n_n[QW-1]};
                    n_n = n_n << 1;
                    if (n_t >= (QW+1)'(r_dm[k-1])) begin
                        n_rem = n_t - (QW+1)'(r_dm[k-1]);
                        n_q   = {n_q[QW-2:0], 1'b1};
                    end else begin
                        n_rem = n_t;
                        n_q   = {n_q[QW-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                r_drem[k] <= n_rem;
                r_dq[k]   <= n_q;
                r_dn[k]   <= n_n;
                r_dm[k]   <= r_dm[k-1];
            end
        end
    endgenerate

    // the two fractions add up to 2^31, less one when the division is inexact
    always_ff @(posedge i_clk) begin
        if (r_dm[DS] == '0) begin
            r_fa[DIV_LAT] <= QW'(1) << dec_pkg::FRAC_SH;
            r_fb[DIV_LAT] <= QW'(1) << dec_pkg::FRAC_SH;
        end else begin
            r_fa[DIV_LAT] <= r_dq[DS];
            r_fb[DIV_LAT] <= (QW'(1) << (dec_pkg::FRAC_SH + 1)) - r_dq[DS]
                           - QW'(r_drem[DS] != '0);
        end
    end

    generate
        for (s = DIV_LAT + 1; s <= S_DIFF; s++) begin : g_fd
            always_ff @(posedge i_clk) begin
                r_fa[s] <= r_fa[s-1];
                r_fb[s] <= r_fb[s-1];
            end
        end
    endgenerate

    // ---------------- normalize ----------------
    dec_pkg::t_xy n_nv1, n_nv2;
    logic [W-1:0] n_mag1, n_mag2;

    always_comb begin
        n_nv1  = r_cv[0];
        n_mag1 = W'(r_cv[0].x) | (r_cv[0].y[W-1] ? W'(-r_cv[0].y) : W'(r_cv[0].y));
        for (int j = 0; j < 3; j++) begin
            if ((n_mag1 >> (dec_pkg::NORM_TOP - (HW >> j))) == '0) begin
                n_mag1  = n_mag1 << (HW >> j);
                n_nv1.x = n_nv1.x <<< (HW >> j);
                n_nv1.y = n_nv1.y <<< (HW >> j);
            end
        end
    end

    always_comb begin
        n_nv2  = r_cv[1];
        n_mag2 = r_mag;
        for (int j = 3; j < 6; j++) begin
            if ((n_mag2 >> (dec_pkg::NORM_TOP - (HW >> j))) == '0) begin
                n_mag2  = n_mag2 << (HW >> j);
                n_nv2.x = n_nv2.x <<< (HW >> j);
                n_nv2.y = n_nv2.y <<< (HW >> j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cv[1] <= n_nv1;
        r_mag   <= n_mag1;
        r_cv[2] <= n_nv2;
    end

    // ---------------- velocity pipe ----------------
    logic signed [W-1:0] r_dab, r_dba;
    logic signed [PW-1:0] w_ea, w_eb;

    generate
        for (s = 1; s <= S_GAIN; s++) begin : g_vel
            if (s >= S_ROT0 && s <= S_ROTL) begin : g_fwd
                logic n_cw;
                logic [N-1:0] n_dv;
                always_comb begin
                    n_cw = !r_cv[s-1].y[W-1];
                    if (s == S_ROT0) begin
                        n_dv = '0;
                    end else begin
                        n_dv = r_dir[(s == S_ROT0) ? S_ROT0 : s-1];
                    end
                    n_dv[s-S_ROT0] = n_cw;
                end
                always_ff @(posedge i_clk) begin
                    r_cv[s]  <= dec_pkg::turn(r_cv[s-1], s - S_ROT0, n_cw);
                    r_dir[s] <= n_dv;
                    if (r_fr[s-1]) begin
                        r_wv[s].a <= dec_pkg::turn(r_wv[s-1].a, s - S_ROT0, n_cw);
                        r_wv[s].b <= dec_pkg::turn(r_wv[s-1].b, s - S_ROT0, n_cw);
                    end else begin
                        r_wv[s] <= r_wv[s-1];
                    end
                end
            end else if (s == S_EXC) begin : g_exc
                // normal parts traded, both from the values before the exchange
                always_ff @(posedge i_clk) begin
                    r_dir[s]   <= r_dir[s-1];
                    r_wv[s].a.x <= r_wv[s-1].a.x + W'(w_ea >>> dec_pkg::FRAC_SH);
                    r_wv[s].b.x <= r_wv[s-1].b.x + W'(w_eb >>> dec_pkg::FRAC_SH);
                    r_wv[s].a.y <= r_wv[s-1].a.y;
                    r_wv[s].b.y <= r_wv[s-1].b.y;
                end
            end else if (s > S_EXC && s <= S_BKL) begin : g_bck
                always_ff @(posedge i_clk) begin
                    r_dir[s] <= r_dir[s-1];
                    if (r_fr[s-1]) begin
                        r_wv[s].a <= dec_pkg::turn(r_wv[s-1].a, S_BKL - s,
                                                   !r_dir[s-1][S_BKL-s]);
                        r_wv[s].b <= dec_pkg::turn(r_wv[s-1].b, S_BKL - s,
                                                   !r_dir[s-1][S_BKL-s]);
                    end else begin
                        r_wv[s] <= r_wv[s-1];
                    end
                end
            end else if (s > S_ROTL && s < S_EXC) begin : g_mid
                always_ff @(posedge i_clk) begin
                    r_dir[s] <= r_dir[s-1];
                    r_wv[s]  <= r_wv[s-1];
                end
            end else begin : g_cpy
                always_ff @(posedge i_clk) begin
                    r_wv[s] <= r_wv[s-1];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_dab <= r_wv[S_ROTL].b.x - r_wv[S_ROTL].a.x;
        r_dba <= r_wv[S_ROTL].a.x - r_wv[S_ROTL].b.x;
    end

    dec_wmul u_mul_ea (.i_clk(i_clk), .i_a(r_dab), .i_b(signed'(W'(r_fa[S_DIFF]))),
                       .o_p(w_ea));
    dec_wmul u_mul_eb (.i_clk(i_clk), .i_a(r_dba), .i_b(signed'(W'(r_fb[S_DIFF]))),
                       .o_p(w_eb));

    // ---------------- gain and output ----------------
    logic signed [PW-1:0] w_gax, w_gay, w_gbx, w_gby;

    dec_wmul u_mul_gax (.i_clk(i_clk), .i_a(r_wv[S_BKL].a.x), .i_b(G), .o_p(w_gax));
    dec_wmul u_mul_gay (.i_clk(i_clk), .i_a(r_wv[S_BKL].a.y), .i_b(G), .o_p(w_gay));
    dec_wmul u_mul_gbx (.i_clk(i_clk), .i_a(r_wv[S_BKL].b.x), .i_b(G), .o_p(w_gbx));
    dec_wmul u_mul_gby (.i_clk(i_clk), .i_a(r_wv[S_BKL].b.y), .i_b(G), .o_p(w_gby));

    function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [W-1:0] v);
        if ((&v[W-1:COORD_WIDTH-1]) || !(|v[W-1:COORD_WIDTH-1])) begin
            return v[COORD_WIDTH-1:0];
        end else if (v[W-1]) begin
            return {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    dec_pkg::t_quad n_fin;

    always_comb begin
        if (!r_ap[S_GAIN]) begin
            n_fin = r_ov[S_GAIN];
        end else if (r_fr[S_GAIN]) begin
            n_fin.a.x = W'(w_gax >>> dec_pkg::GAIN_SH);
            n_fin.a.y = W'(w_gay >>> dec_pkg::GAIN_SH);
            n_fin.b.x = W'(w_gbx >>> dec_pkg::GAIN_SH);
            n_fin.b.y = W'(w_gby >>> dec_pkg::GAIN_SH);
        end else begin
            n_fin = r_wv[S_GAIN];
        end
    end

    logic signed [COORD_WIDTH-1:0] r_res_ax, r_res_ay, r_res_bx, r_res_by;
    logic                          r_res_ok;

    always_ff @(posedge i_clk) begin
        r_res_ax <= sat(n_fin.a.x);
        r_res_ay <= sat(n_fin.a.y);
        r_res_bx <= sat(n_fin.b.x);
        r_res_by <= sat(n_fin.b.y);
        r_res_ok <= r_ap[S_GAIN];
    end

    assign o_new_vel_a_x = r_res_ax;
    assign o_new_vel_a_y = r_res_ay;
    assign o_new_vel_b_x = r_res_bx;
    assign o_new_vel_b_y = r_res_by;
    assign o_resolved    = r_res_ok;

endmodule

// ----- hw/rtl/dec_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dec_chk
// port-level checks of the disc collision unit, bound to the top level
// ----------------------------------------------------------------------------
`include "disc_elastic_collision_unit_defines.svh"

module dec_chk #(
    parameter int COORD_WIDTH   = dec_pkg::COORD_WIDTH_DEF,
    parameter int ROTATOR_STEPS = dec_pkg::ROTATOR_STEPS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          o_busy,
    input logic signed [COORD_WIDTH-1:0] i_pos_a_x,
    input logic signed [COORD_WIDTH-1:0] i_pos_a_y,
    input logic signed [COORD_WIDTH-1:0] i_vel_a_x,
    input logic signed [COORD_WIDTH-1:0] i_vel_a_y,
    input logic [dec_pkg::RADIUS_W-1:0]  i_radius_a,
    input logic signed [COORD_WIDTH-1:0] i_pos_b_x,
    input logic signed [COORD_WIDTH-1:0] i_pos_b_y,
    input logic signed [COORD_WIDTH-1:0] i_vel_b_x,
    input logic signed [COORD_WIDTH-1:0] i_vel_b_y,
    input logic [dec_pkg::RADIUS_W-1:0]  i_radius_b,
    input logic                          o_done,
    input logic signed [COORD_WIDTH-1:0] o_new_vel_a_x,
    input logic signed [COORD_WIDTH-1:0] o_new_vel_a_y,
    input logic signed [COORD_WIDTH-1:0] o_new_vel_b_x,
    input logic signed [COORD_WIDTH-1:0] o_new_vel_b_y,
    input logic                          o_resolved
);

    localparam int LAT = 2 * ROTATOR_STEPS + 12;

    // every request gives exactly one result after the fixed latency
    `DEC_ASSERT_DLY(a_req_done, i_clk, i_rst_n, i_start, LAT, o_done, "request lost")
    `DEC_ASSERT(a_done_req, i_clk, i_rst_n, o_done, $past(i_start, LAT), "result invented")
    // separating discs return their own velocities
    `DEC_ASSERT(a_pass_a, i_clk, i_rst_n, o_done && !o_resolved,
        o_new_vel_a_x == $past(i_vel_a_x, LAT) && o_new_vel_a_y == $past(i_vel_a_y, LAT),
        "pass-through a mismatch")
    `DEC_ASSERT(a_pass_b, i_clk, i_rst_n, o_done && !o_resolved,
        o_new_vel_b_x == $past(i_vel_b_x, LAT) && o_new_vel_b_y == $past(i_vel_b_y, LAT),
        "pass-through b mismatch")

endmodule

bind disc_elastic_collision_unit dec_chk #(
    .COORD_WIDTH(COORD_WIDTH),
    .ROTATOR_STEPS(ROTATOR_STEPS)
) u_dec_chk (.*);

// ----- dv/disc_elastic_collision_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disc_elastic_collision_unit_tb
// checks each disc pair request against a typed expectation or an in-bench collision predictor
// ----------------------------------------------------------------------------
// A directed table comes first: pairs that separate, coincident centres,
// zero and extreme radii, and saturating head-on hits. A few rows carry a
// typed expectation. Random pairs follow, most of them set up to approach.
// Requests go out in random bursts. Every o_done result is compared field
// by field with the oldest expectation.
// ----------------------------------------------------------------------------
module disc_elastic_collision_unit_tb;

    localparam int CW        = dec_pkg::COORD_WIDTH_DEF;
    localparam int STEPS     = dec_pkg::ROTATOR_STEPS_DEF;
    localparam int LATENCY   = 2 * STEPS + 12;
    localparam int N_RANDOM  = 1530;
    localparam int MAX_CYCLE = 400000;

    typedef logic signed [CW-1:0]          t_coord;
    typedef logic [dec_pkg::RADIUS_W-1:0]  t_radius;
    typedef logic signed [63:0]            t_s64;
    typedef logic signed [127:0]           t_s128;

    typedef struct {
        t_coord  pax, pay, vax, vay;
        t_radius ra;
        t_coord  pbx, pby, vbx, vby;
        t_radius rb;
    } t_pair;

    typedef struct packed {
        t_coord vax, vay, vbx, vby;
        logic   resolved;
    } t_velo;

    // what a table row already knows about its result
    typedef enum logic [1:0] {
        EXP_PREDICT,
        EXP_PASS,
        EXP_STILL
    } t_row_exp;

    logic    i_clk, i_rst_n, i_start;
    logic    o_busy, o_done, o_resolved;
    t_coord  i_pos_a_x, i_pos_a_y, i_vel_a_x, i_vel_a_y;
    t_coord  i_pos_b_x, i_pos_b_y, i_vel_b_x, i_vel_b_y;
    t_radius i_radius_a, i_radius_b;
    t_coord  o_new_vel_a_x, o_new_vel_a_y, o_new_vel_b_x, o_new_vel_b_y;

    disc_elastic_collision_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_pos_a_x     (i_pos_a_x),
        .i_pos_a_y     (i_pos_a_y),
        .i_vel_a_x     (i_vel_a_x),
        .i_vel_a_y     (i_vel_a_y),
        .i_radius_a    (i_radius_a),
        .i_pos_b_x     (i_pos_b_x),
        .i_pos_b_y     (i_pos_b_y),
        .i_vel_b_x     (i_vel_b_x),
        .i_vel_b_y     (i_vel_b_y),
        .i_radius_b    (i_radius_b),
        .o_done        (o_done),
        .o_new_vel_a_x (o_new_vel_a_x),
        .o_new_vel_a_y (o_new_vel_a_y),
        .o_new_vel_b_x (o_new_vel_b_x),
        .o_new_vel_b_y (o_new_vel_b_y),
        .o_resolved    (o_resolved)
    );

    t_pair    pair_table[$];
    t_row_exp row_kind[$];
    t_velo    velo_expected[$];
    t_row_exp cur_kind;
    int       mismatches;
    int       cycles;
    logic     stim_done;

    function automatic t_s128 mul_wide(input t_s64 a, input t_s64 b);
        t_s128 wa, wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    function automatic void micro_turn(inout t_s64 x, inout t_s64 y, input int sh,
                                       input bit cw);
        t_s64 ox, oy;
        ox = x;
        oy = y;
        if (cw) begin
            x = ox + (oy >>> sh);
            y = oy - (ox >>> sh);
        end else begin
            x = ox - (oy >>> sh);
            y = oy + (ox >>> sh);
        end
    endfunction

    function automatic t_coord clamp_coord(input t_s64 v);
        t_s64 hi, lo;
        hi = (t_s64'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi[CW-1:0];
        if (v < lo) return lo[CW-1:0];
        return v[CW-1:0];
    endfunction

    function automatic t_s64 elastic_trade(input t_s64 self_v, input t_s64 other_v,
                                           input t_s64 frac);
        t_s64 delta;
        delta = mul_wide(other_v - self_v, frac) >>> dec_pkg::FRAC_SH;
        return self_v + delta;
    endfunction

    function automatic t_velo resolve_pair(input t_pair p);
        t_s64    dx, dy, dvx, dvy, nx, ny, vax, vay, vbx, vby, fa, fb, na;
        t_s128   closing;
        logic [63:0] sum, g;
        bit      cw_dir[STEPS];
        bit      framed;
        t_velo   r;
        vax = p.vax; vay = p.vay; vbx = p.vbx; vby = p.vby;
        dx  = t_s64'(p.pax) - t_s64'(p.pbx);
        dy  = t_s64'(p.pay) - t_s64'(p.pby);
        dvx = vax - vbx;
        dvy = vay - vby;
        closing = mul_wide(200 * dx, dvx) + mul_wide(200 * dy, dvy)
                + mul_wide(dvx, dvx) + mul_wide(dvy, dvy);
        if (closing > 0) begin
            r.vax = p.vax; r.vay = p.vay; r.vbx = p.vbx; r.vby = p.vby;
            r.resolved = 1'b0;
            return r;
        end
        nx = -dx;
        ny = -dy;
        if (nx < 0) begin
            nx = -nx;
            ny = -ny;
        end
        framed = (nx != 0) || (ny != 0);
        if (framed) begin
            while ((nx < 0 ? -nx : nx) < (t_s64'(1) <<< 59)
                   && (ny < 0 ? -ny : ny) < (t_s64'(1) <<< 59)) begin
                nx = nx * 2;
                ny = ny * 2;
            end
            for (int i = 0; i < STEPS; i++) begin
                cw_dir[i] = (ny >= 0);
                micro_turn(nx, ny, i, cw_dir[i]);
            end
            for (int i = 0; i < STEPS; i++) begin
                micro_turn(vax, vay, i, cw_dir[i]);
                micro_turn(vbx, vby, i, cw_dir[i]);
            end
        end
        sum = 64'(p.ra) + 64'(p.rb);
        if (sum == 0) begin
            fa = t_s64'(1) <<< 30;
            fb = fa;
        end else begin
            fa = ((64'(p.rb) * 2) << 30) / sum;
            fb = ((64'(p.ra) * 2) << 30) / sum;
        end
        // both sides use the pre-exchange normal components
        na  = elastic_trade(vax, vbx, fa);
        vbx = elastic_trade(vbx, vax, fb);
        vax = na;
        if (framed) begin
            for (int i = STEPS - 1; i >= 0; i--) begin
                micro_turn(vax, vay, i, !cw_dir[i]);
                micro_turn(vbx, vby, i, !cw_dir[i]);
            end
            g = 64'd1 << 61;
            for (int i = 0; i < STEPS; i++)
                g = g - g / ((64'd1 << (2 * i)) + 64'd1);
            vax = mul_wide(vax, t_s64'(g)) >>> 61;
            vay = mul_wide(vay, t_s64'(g)) >>> 61;
            vbx = mul_wide(vbx, t_s64'(g)) >>> 61;
            vby = mul_wide(vby, t_s64'(g)) >>> 61;
        end
        r.vax = clamp_coord(vax);
        r.vay = clamp_coord(vay);
        r.vbx = clamp_coord(vbx);
        r.vby = clamp_coord(vby);
        r.resolved = 1'b1;
        return r;
    endfunction

    task automatic add_row(input t_coord pax, pay, vax, vay, input t_radius ra,
                           input t_coord pbx, pby, vbx, vby, input t_radius rb,
                           input t_row_exp kind);
        t_pair p;
        p.pax = pax; p.pay = pay; p.vax = vax; p.vay = vay; p.ra = ra;
        p.pbx = pbx; p.pby = pby; p.vbx = vbx; p.vby = vby; p.rb = rb;
        pair_table.push_back(p);
        row_kind.push_back(kind);
    endtask

    function automatic t_pair random_pair();
        t_pair p;
        int    shape;
        int    sh;
        shape = $urandom_range(0, 9);
        p.pax = $urandom; p.pay = $urandom; p.vax = $urandom; p.vay = $urandom;
        p.pbx = $urandom; p.pby = $urandom; p.vbx = $urandom; p.vby = $urandom;
        p.ra  = t_radius'($urandom);
        p.rb  = t_radius'($urandom);
        if (shape < 7) begin
            // nearby discs moving toward each other
            p.pax = $signed(p.pax) >>> $urandom_range(4, 14);
            p.pay = $signed(p.pay) >>> $urandom_range(4, 14);
            p.pbx = $signed(p.pbx) >>> $urandom_range(4, 14);
            p.pby = $signed(p.pby) >>> $urandom_range(4, 14);
            p.vbx = $signed(p.vbx) >>> $urandom_range(4, 14);
            p.vby = $signed(p.vby) >>> $urandom_range(4, 14);
            sh = $urandom_range(0, 6);
            p.vax = p.vbx + ((p.pbx - p.pax) >>> sh) + $signed(4'($urandom));
            p.vay = p.vby + ((p.pby - p.pay) >>> sh) + $signed(4'($urandom));
            if ($urandom_range(0, 3) == 0) p.ra = p.ra >> $urandom_range(10, 29);
            if ($urandom_range(0, 3) == 0) p.rb = p.rb >> $urandom_range(10, 29);
        end else if (shape == 7) begin
            // shared centre, sometimes with equal velocities
            p.pbx = p.pax;
            p.pby = p.pay;
            if ($urandom_range(0, 1)) begin
                p.vbx = p.vax;
                p.vby = p.vay;
            end
        end
        return p;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // request and result side: accept, predict, and check results
    always @(posedge i_clk) begin
        t_velo e, got;
        if (i_rst_n && i_start && !o_busy) begin
            if (cur_kind == EXP_PREDICT) begin
                e = resolve_pair('{i_pos_a_x, i_pos_a_y, i_vel_a_x, i_vel_a_y, i_radius_a,
                                   i_pos_b_x, i_pos_b_y, i_vel_b_x, i_vel_b_y, i_radius_b});
            end else begin
                e.vax = i_vel_a_x; e.vay = i_vel_a_y;
                e.vbx = i_vel_b_x; e.vby = i_vel_b_y;
                e.resolved = (cur_kind == EXP_STILL);
            end
            velo_expected.push_back(e);
        end
        if (i_rst_n && o_done) begin
            got = '{o_new_vel_a_x, o_new_vel_a_y, o_new_vel_b_x, o_new_vel_b_y, o_resolved};
            if (velo_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with nothing pending at cycle %0d", cycles);
            end else begin
                e = velo_expected.pop_front();
                if (got != e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch cycle %0d: exp %h %h %h %h %b got %h %h %h %h %b",
                                 cycles, e.vax, e.vay, e.vbx, e.vby, e.resolved,
                                 got.vax, got.vay, got.vbx, got.vby, got.resolved);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        localparam t_coord MAXC = {1'b0, {(CW-1){1'b1}}};
        localparam t_coord MINC = {1'b1, {(CW-1){1'b0}}};
        localparam t_radius MAXR = '1;
        localparam t_coord ONE = 32'sh0001_0000;
        localparam t_radius RONE = 30'h0001_0000;
        localparam t_radius RTWO = 30'h0002_0000;
        t_pair p;
        int    burst;
        int    n_sent;
        mismatches = 0;
        cycles     = 0;
        stim_done  = 1'b0;
        cur_kind   = EXP_PREDICT;
        i_rst_n = 1'b0; i_start = 1'b0;
        {i_pos_a_x, i_pos_a_y, i_vel_a_x, i_vel_a_y, i_radius_a} = '0;
        {i_pos_b_x, i_pos_b_y, i_vel_b_x, i_vel_b_y, i_radius_b} = '0;

        // the first rows, separating and coincident pairs, carry typed expectations
        add_row(0, 0, -ONE, 0, RONE, ONE, 0, ONE, 0, RONE, EXP_PASS);
        add_row(5, 7, 3, -4, 100, 5, 7, 3, -4, 900, EXP_STILL);
        add_row(-9, 2, ONE, ONE, 0, -9, 2, ONE, ONE, 0, EXP_STILL);
        add_row(ONE, ONE, ONE, 0, 1, ONE, ONE, -ONE, 0, 1, EXP_PASS);
        add_row(MAXC, MAXC, MAXC, MAXC, MAXR, MAXC, MAXC, MAXC, MAXC, MAXR, EXP_STILL);
        add_row(0, 0, ONE, 0, RONE, 2 * ONE, 0, -ONE, 0, RONE, EXP_PREDICT);
        add_row(0, 0, 0, ONE, RONE, 0, 3 * ONE, 0, -ONE, RTWO, EXP_PREDICT);
        add_row(ONE, ONE, -ONE, -ONE, RONE, 0, 0, ONE, ONE, RONE, EXP_PREDICT);
        add_row(2 * ONE, 0, -ONE, ONE, 5, 0, ONE, ONE, 0, 7, EXP_PREDICT);
        add_row(0, 0, MAXC, 0, 1, ONE, 0, MINC, 0, MAXR, EXP_PREDICT);
        add_row(0, 0, MAXC, MAXC, MAXR, ONE, ONE, MINC, MINC, 1, EXP_PREDICT);
        add_row(MINC, MINC, MAXC, MAXC, MAXR, MAXC, MAXC, MINC, MINC, MAXR, EXP_PREDICT);
        add_row(MAXC, MINC, MINC, MAXC, 1, MINC, MAXC, MAXC, MINC, 1, EXP_PREDICT);
        add_row(0, 0, ONE, ONE, 0, ONE, ONE, -ONE, -ONE, 0, EXP_PREDICT);
        add_row(-1, -1, 1, 1, MAXR, 0, 0, 0, 0, MAXR, EXP_PREDICT);
        add_row(0, 0, MINC, 0, 1, MINC, 0, MAXC, 0, 1, EXP_PREDICT);
        add_row(0, 0, 0, -ONE, 3, 0, -ONE, 0, ONE, 3, EXP_PREDICT);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        n_sent = 0;
        while (n_sent < pair_table.size() + N_RANDOM) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 12);
            for (int k = 0; k < burst && n_sent < pair_table.size() + N_RANDOM; k++) begin
                @(negedge i_clk);
                if (n_sent < pair_table.size()) begin
                    p = pair_table[n_sent];
                    cur_kind <= row_kind[n_sent];
                end else begin
                    p = random_pair();
                    cur_kind <= EXP_PREDICT;
                end
                i_pos_a_x <= p.pax; i_pos_a_y <= p.pay;
                i_vel_a_x <= p.vax; i_vel_a_y <= p.vay; i_radius_a <= p.ra;
                i_pos_b_x <= p.pbx; i_pos_b_y <= p.pby;
                i_vel_b_x <= p.vbx; i_vel_b_y <= p.vby; i_radius_b <= p.rb;
                i_start   <= 1'b1;
                @(posedge i_clk);
                while (o_busy) @(posedge i_clk);
                n_sent++;
            end
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 10)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_start   <= 1'b0;
        stim_done <= 1'b1;

        while (velo_expected.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (mismatches == 0 && velo_expected.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
